FILE: hw/rtl/jbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JVM bytecode predecoder package
// Shared types and constants for the predecoder front and back parts.
// ----------------------------------------------------------------------------
package jbp_pkg;

	localparam int ADDR_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] OP_LAST_KNOWN = 8'hc9;
	localparam logic [7:0] OP_TABLE_SWITCH = 8'haa;
	localparam logic [7:0] OP_LOOKUP_SWITCH = 8'hab;
	localparam logic [7:0] OP_WIDE = 8'hc4;
	localparam logic [7:0] OP_UNUSED_BA = 8'hba;
	localparam logic [7:0] OP_IINC = 8'h84;
	localparam logic [7:0] OP_PUSH_BYTE = 8'h10;
	localparam logic [7:0] OP_PUSH_SHORT = 8'h11;
	localparam logic [7:0] OP_RET = 8'ha9;
	localparam logic [7:0] OP_NEW_PRIM_ARRAY = 8'hbc;
	localparam logic [7:0] OP_CALL_IFACE = 8'hb9;
	localparam logic [7:0] OP_NEW_MULTI_ARRAY = 8'hc5;
	localparam logic [7:0] OP_GOTO_WIDE = 8'hc8;
	localparam logic [7:0] OP_JSR_WIDE = 8'hc9;

	typedef enum logic [3:0] {
		PH_OPCODE, PH_OPERANDS, PH_PAD, PH_DEFAULT, PH_LOW, PH_HIGH,
		PH_NPAIRS, PH_TENTRY, PH_MATCH, PH_OFFSET
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_UNKNOWN = 3'd1, ST_WIDE = 3'd2, ST_RESERVED = 3'd3,
		ST_TRUNCATED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0, KIND_LOCAL = 2'd1, KIND_POOL = 2'd2
	} kind_t;

	// Classified work item handed from the front part to the back part.
	typedef struct packed {
		logic        entry;
		logic [31:0] start;
		logic [7:0]  opc;
		logic [31:0] word;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] tgt;
		logic        tv;
		logic        raw;
		logic [2:0]  st;
	} work_t;

	typedef struct packed {
		logic [15:0] start_address;
		logic [7:0]  opcode;
		logic        table_entry;
		logic [1:0]  index_kind;
		logic [15:0] index_value;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic [31:0] target;
		logic        target_valid;
		logic        pool_index_bad;
		logic [2:0]  status;
	} result_t;

	function automatic logic [2:0] operand_bytes(input logic [7:0] op);
		logic [2:0] n;
		n = 3'd0;
		if (op == 8'h10 || op == 8'h12 || (op >= 8'h15 && op <= 8'h19) ||
			(op >= 8'h36 && op <= 8'h3a) || op == 8'ha9 || op == 8'hbc)
			n = 3'd1;
		else if (op == 8'h11 || op == 8'h13 || op == 8'h14 || op == 8'h84 ||
			(op >= 8'h99 && op <= 8'ha8) || (op >= 8'hb2 && op <= 8'hb8) ||
			op == 8'hbb || op == 8'hbd || op == 8'hc0 || op == 8'hc1 ||
			op == 8'hc6 || op == 8'hc7)
			n = 3'd2;
		else if (op == 8'hc5)
			n = 3'd3;
		else if (op == 8'hb9 || op == 8'hc8 || op == 8'hc9)
			n = 3'd4;
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/jbp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Predecoder channel interfaces
// Valid/ready channels for code bytes, configuration and results.
// ----------------------------------------------------------------------------
interface jbp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       method_first;
	logic       method_last;
	modport source(output valid, code_byte, method_first, method_last, input ready);
	modport sink(input valid, code_byte, method_first, method_last, output ready);
endinterface

interface jbp_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

interface jbp_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] start_address;
	logic [7:0]  opcode;
	logic        table_entry;
	logic [1:0]  index_kind;
	logic [15:0] index_value;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	logic [31:0] target;
	logic        target_valid;
	logic        pool_index_bad;
	logic [2:0]  status;
	modport source(output valid, start_address, opcode, table_entry, index_kind,
		index_value, operand_a, operand_b, target, target_valid, pool_index_bad,
		status, input ready);
	modport sink(input valid, start_address, opcode, table_entry, index_kind,
		index_value, operand_a, operand_b, target, target_valid, pool_index_bad,
		status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/jbp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Predecoder front part
// Tracks the code address and splits the byte stream into instructions.
// ----------------------------------------------------------------------------
module jbp_front import jbp_pkg::*; #(
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [7:0]  code_byte,
	input  wire logic        method_first,
	input  wire logic        method_last,
	output logic             work_valid,
	output work_t            work
);

	logic [ADDR_WIDTH-1:0] addr_q, start_q;
	logic [7:0]  opc_q;
	phase_t      phase_q;
	logic [2:0]  left_q;
	logic [31:0] word_q, dflt_q, key_q, ent_q;
	logic        halted_q;

	logic [ADDR_WIDTH-1:0] a, a1, addr_d, start_d;
	logic [7:0]  opc_d;
	phase_t      ph, phase_d;
	logic [2:0]  left, left_d;
	logic [31:0] word_d, dflt_d, key_d, ent_d, nw, diff, st32;
	logic        halted, halted_d, have;
	work_t       w;

	assign st32 = 32'(start_q);

	always_comb begin
		ph = phase_q;
		left = left_q;
		halted = halted_q;
		if (method_first) begin
			ph = PH_OPCODE;
			left = 3'd0;
			halted = 1'b0;
		end
		a = method_first ? '0 : addr_q;
		a1 = a + 1'b1;
		nw = {(method_first ? 24'd0 : word_q[23:0]), code_byte};
		diff = nw - key_q;
		addr_d = addr_q;
		start_d = start_q;
		opc_d = opc_q;
		phase_d = ph;
		left_d = left;
		word_d = method_first ? 32'd0 : word_q;
		dflt_d = dflt_q;
		key_d = key_q;
		ent_d = method_first ? 32'd0 : ent_q;
		halted_d = halted;
		have = 1'b0;
		w = '0;
		w.start = 32'(start_q);
		w.opc = opc_q;
		if (in_valid && !halted) begin
			addr_d = a1;
			case (ph)
				PH_OPCODE: begin
					start_d = a;
					opc_d = code_byte;
					word_d = 32'd0;
					w.start = 32'(a);
					w.opc = code_byte;
					if (code_byte > OP_LAST_KNOWN || code_byte == OP_UNUSED_BA ||
						code_byte == OP_WIDE) begin
						w.st = (code_byte == OP_WIDE) ? ST_WIDE : ST_UNKNOWN;
						have = 1'b1;
					end else if (code_byte == OP_TABLE_SWITCH ||
						code_byte == OP_LOOKUP_SWITCH) begin
						left_d = 3'd4;
						phase_d = (a1[1:0] == 2'd0) ? PH_DEFAULT : PH_PAD;
					end else if (operand_bytes(code_byte) != 3'd0) begin
						left_d = operand_bytes(code_byte);
						phase_d = PH_OPERANDS;
					end else begin
						w.raw = 1'b1;
						have = 1'b1;
					end
				end
				PH_OPERANDS: begin
					word_d = nw;
					left_d = (left != 3'd0) ? left - 3'd1 : 3'd0;
					if (left_d == 3'd0) begin
						w.raw = 1'b1;
						w.word = nw;
						have = 1'b1;
						phase_d = PH_OPCODE;
						if (opc_q == OP_CALL_IFACE && code_byte != 8'd0)
							w.st = ST_RESERVED;
					end
				end
				PH_PAD: begin
					if (a1[1:0] == 2'd0) begin
						phase_d = PH_DEFAULT;
						left_d = 3'd4;
						word_d = 32'd0;
					end
				end
				default: begin
					word_d = nw;
					left_d = (left != 3'd0) ? left - 3'd1 : 3'd0;
					if (left_d == 3'd0) begin
						word_d = 32'd0;
						left_d = 3'd4;
						case (ph)
							PH_DEFAULT: begin
								dflt_d = st32 + nw;
								phase_d = (opc_q == OP_TABLE_SWITCH) ? PH_LOW : PH_NPAIRS;
							end
							PH_LOW: begin
								key_d = nw;
								phase_d = PH_HIGH;
							end
							PH_HIGH: begin
								w.a = key_q;
								w.b = nw;
								w.tgt = dflt_q;
								w.tv = 1'b1;
								have = 1'b1;
								if ($signed(nw) < $signed(key_q))
									ent_d = 32'd0;
								else
									ent_d = (diff == 32'hffffffff) ? diff : diff + 32'd1;
								phase_d = (ent_d != 32'd0) ? PH_TENTRY : PH_OPCODE;
							end
							PH_NPAIRS: begin
								w.a = nw;
								w.tgt = dflt_q;
								w.tv = 1'b1;
								have = 1'b1;
								ent_d = nw[31] ? 32'd0 : nw;
								phase_d = (ent_d != 32'd0) ? PH_MATCH : PH_OPCODE;
							end
							PH_MATCH: begin
								key_d = nw;
								phase_d = PH_OFFSET;
							end
							default: begin
								w.entry = 1'b1;
								w.start = 32'(a - ADDR_WIDTH'((ph == PH_TENTRY) ? 3 : 7));
								w.a = key_q;
								w.tgt = st32 + nw;
								w.tv = 1'b1;
								have = 1'b1;
								if (ph == PH_TENTRY)
									key_d = key_q + 32'd1;
								ent_d = (ent_d != 32'd0) ? ent_d - 32'd1 : 32'd0;
								if (ent_d == 32'd0)
									phase_d = PH_OPCODE;
								else if (ph == PH_OFFSET)
									phase_d = PH_MATCH;
							end
						endcase
					end
				end
			endcase
			if (have && w.st != ST_OK) begin
				halted_d = 1'b1;
				phase_d = PH_OPCODE;
			end
			if (method_last) begin
				if (phase_d != PH_OPCODE) begin
					if (!have) begin
						w = '0;
						w.start = 32'(start_d);
						w.opc = opc_d;
						have = 1'b1;
					end
					w.st = ST_TRUNCATED;
				end
				halted_d = 1'b1;
				phase_d = PH_OPCODE;
			end
		end else if (in_valid && method_first) begin
			addr_d = a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			start_q <= '0;
			opc_q <= '0;
			phase_q <= PH_OPCODE;
			left_q <= '0;
			word_q <= '0;
			dflt_q <= '0;
			key_q <= '0;
			ent_q <= '0;
			halted_q <= 1'b0;
		end else if (in_valid) begin
			addr_q <= addr_d;
			start_q <= start_d;
			opc_q <= opc_d;
			phase_q <= phase_d;
			left_q <= left_d;
			word_q <= word_d;
			dflt_q <= dflt_d;
			key_q <= key_d;
			ent_q <= ent_d;
			halted_q <= halted_d;
		end
	end

	assign work_valid = in_valid && have;
	assign work = w;

endmodule
`default_nettype wire

FILE: hw/rtl/jbp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Predecoder work queue
// Small FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module jbp_queue import jbp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  work_t      push_data,
	output logic       full,
	output logic       empty,
	input  wire logic  pop,
	output work_t      pop_data
);

	work_t      mem_q [QUEUE_DEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(QUEUE_DEPTH));
	assign empty = (cnt_q == 2'd0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full)
				wp_q <= ~wp_q;
			if (pop && !empty)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/jbp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Predecoder back part
// Extracts indexes, immediates and targets and registers the result.
// ----------------------------------------------------------------------------
module jbp_back import jbp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  work_valid,
	input  work_t      work,
	output logic       work_ready,
	input  wire logic [15:0] pool_count,
	output logic       res_valid,
	input  wire logic  res_ready,
	output result_t    res
);

	result_t r;
	logic [7:0]  op;
	logic [31:0] v, st32;
	logic        res_valid_q;
	result_t     res_q;

	always_comb begin
		op = work.opc;
		v = work.word;
		st32 = work.start;
		r = '0;
		r.start_address = work.start[15:0];
		r.opcode = op;
		r.table_entry = work.entry;
		r.operand_a = work.a;
		r.operand_b = work.b;
		r.target = work.tgt;
		r.target_valid = work.tv;
		r.status = work.st;
		if (work.raw) begin
			case (op) inside
				OP_PUSH_BYTE: r.operand_a = {{24{v[7]}}, v[7:0]};
				OP_PUSH_SHORT: r.operand_a = {{16{v[15]}}, v[15:0]};
				[8'h12:8'h14], [8'hb2:8'hb8], 8'hbb, 8'hbd, 8'hc0, 8'hc1: begin
					r.index_kind = KIND_POOL;
					r.index_value = v[15:0];
				end
				[8'h15:8'h19], [8'h36:8'h3a]: begin
					r.index_kind = KIND_LOCAL;
					r.index_value = {8'd0, v[7:0]};
				end
				[8'h1a:8'h2d]: begin
					r.index_kind = KIND_LOCAL;
					r.index_value = {14'd0, 2'(op - 8'h1a)};
				end
				[8'h3b:8'h4e]: begin
					r.index_kind = KIND_LOCAL;
					r.index_value = {14'd0, 2'(op - 8'h3b)};
				end
				OP_IINC: begin
					r.index_kind = KIND_LOCAL;
					r.index_value = {8'd0, v[15:8]};
					r.operand_a = {{24{v[7]}}, v[7:0]};
				end
				[8'h99:8'ha8], 8'hc6, 8'hc7: begin
					r.target = st32 + {{16{v[15]}}, v[15:0]};
					r.target_valid = 1'b1;
				end
				OP_RET, OP_NEW_PRIM_ARRAY: r.operand_a = {24'd0, v[7:0]};
				OP_CALL_IFACE: begin
					r.index_kind = KIND_POOL;
					r.index_value = v[31:16];
					r.operand_a = {24'd0, v[15:8]};
				end
				OP_NEW_MULTI_ARRAY: begin
					r.index_kind = KIND_POOL;
					r.index_value = v[23:8];
					r.operand_a = {24'd0, v[7:0]};
				end
				OP_GOTO_WIDE, OP_JSR_WIDE: begin
					r.target = st32 + v;
					r.target_valid = 1'b1;
				end
				default: ;
			endcase
		end
		r.pool_index_bad = (r.index_kind == KIND_POOL) &&
			(r.index_value == 16'd0 || r.index_value > pool_count);
	end

	assign work_ready = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (work_ready)
			res_valid_q <= work_valid;
	end

	always_ff @(posedge clk) begin
		if (work_ready && work_valid)
			res_q <= r;
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule
`default_nettype wire

FILE: hw/rtl/jvm_bytecode_predecoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JVM bytecode predecoder
// Splits a method's bytecode stream into instructions and switch entries.
// ----------------------------------------------------------------------------
// One code byte is taken per clock cycle. The front state machine classifies
// each byte in the cycle it is transferred, a two-entry queue holds finished
// items, and the back part extracts operands into a registered output, so a
// result passes through a queue entry and then the output register after its
// last byte, and the input stalls only when the queue is full.
module jvm_bytecode_predecoder_unit import jbp_pkg::*; #(
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	jbp_in_if.sink    code,
	jbp_cfg_if.sink   cfg,
	jbp_out_if.source result
);

	logic [15:0] pool_count_q;
	logic        fv, q_full, q_empty, b_ready;
	work_t       fw, qw;
	result_t     res;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pool_count_q <= '0;
		else if (cfg.valid)
			pool_count_q <= cfg.data;
	end

	assign code.ready = !q_full;

	jbp_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
		.clk, .arst_n,
		.in_valid(code.valid && !q_full),
		.code_byte(code.code_byte),
		.method_first(code.method_first),
		.method_last(code.method_last),
		.work_valid(fv),
		.work(fw)
	);

	jbp_queue u_queue (
		.clk, .arst_n,
		.push(fv), .push_data(fw), .full(q_full), .empty(q_empty),
		.pop(b_ready), .pop_data(qw)
	);

	jbp_back u_back (
		.clk, .arst_n,
		.work_valid(!q_empty), .work(qw), .work_ready(b_ready),
		.pool_count(pool_count_q),
		.res_valid(result.valid), .res_ready(result.ready), .res(res)
	);

	assign result.start_address = res.start_address;
	assign result.opcode = res.opcode;
	assign result.table_entry = res.table_entry;
	assign result.index_kind = res.index_kind;
	assign result.index_value = res.index_value;
	assign result.operand_a = res.operand_a;
	assign result.operand_b = res.operand_b;
	assign result.target = res.target;
	assign result.target_valid = res.target_valid;
	assign result.pool_index_bad = res.pool_index_bad;
	assign result.status = res.status;

endmodule
`default_nettype wire

FILE: hw/rtl/jbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Predecoder port checker
// Assertions on the top level's result port, bound to the predecoder.
// ----------------------------------------------------------------------------
module jbp_checker import jbp_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] out_start,
	input wire logic        out_tv,
	input wire logic [31:0] out_target,
	input wire logic [1:0]  out_kind,
	input wire logic [15:0] out_index,
	input wire logic        out_bad,
	input wire logic        out_entry
);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_start))
		else $error("Stalled result changed.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_tv |-> out_target == 32'd0)
		else $error("Target set without target_valid.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_NONE |-> out_index == 16'd0 && !out_bad)
		else $error("Index present without index kind.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_entry |-> out_tv)
		else $error("Table entry without target.");

endmodule

bind jvm_bytecode_predecoder_unit jbp_checker u_checker (
	.clk(clk), .arst_n(arst_n),
	.out_valid(result.valid), .out_ready(result.ready),
	.out_start(result.start_address), .out_tv(result.target_valid),
	.out_target(result.target), .out_kind(result.index_kind),
	.out_index(result.index_value), .out_bad(result.pool_index_bad),
	.out_entry(result.table_entry)
);
`default_nettype wire
